>>> src/lrtc_pkg.sv
package lrtc_pkg;

	localparam int unsigned MAX_RECORDS = 256;
	localparam int unsigned BANK_BYTES  = 524288;

	// record count clamp: never more than MAX_RECORDS, never more than the index range
	localparam int unsigned CNT_LIMIT = (MAX_RECORDS < 256) ? MAX_RECORDS : 256;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned IDX_W    = 8;
	localparam int unsigned OFF_W    = 19;
	localparam int unsigned CNT_W    = 9;
	localparam int unsigned REG_W    = 5;
	localparam int unsigned BYTES_W  = 34;
	localparam int unsigned BLOCKS_W = 28;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned ADDR_W   = 2;

	localparam int unsigned IN_DATA_W  = 3 * WORD_W;
	localparam int unsigned OUT_FIELD_W = IDX_W + OFF_W + REG_W + BYTES_W + BLOCKS_W + 1
		+ OFF_W + STATUS_W;
	localparam int unsigned OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_FIELD_W;

	// stride end address a + 3b + 16*(N-1) past the word range, with the -16 folded in
	localparam logic [34:0] STRIDE_MAX = 35'h1_0000_000F;

	localparam logic [32:0] BANK_SPAN = 33'(BANK_BYTES);

	// configuration register indexes
	localparam logic [ADDR_W-1:0] CFG_RUNTIME_BASE = 2'd0;
	localparam logic [ADDR_W-1:0] CFG_TABLE_OFFSET = 2'd1;
	localparam logic [ADDR_W-1:0] CFG_RECORD_COUNT = 2'd2;

	localparam logic [WORD_W-1:0] RESET_RUNTIME_BASE = 32'd217579520;
	localparam logic [OFF_W-1:0]  RESET_TABLE_OFFSET = 19'd0;
	localparam logic [CNT_W-1:0]  RESET_RECORD_COUNT = 9'd27;

	// record type codes
	localparam logic [WORD_W-1:0] TYPE_COPY       = 32'd1;
	localparam logic [WORD_W-1:0] TYPE_ZERO       = 32'd2;
	localparam logic [WORD_W-1:0] TYPE_TERMINAL   = 32'd3;
	localparam logic [WORD_W-1:0] TYPE_CALL       = 32'd4;
	localparam logic [WORD_W-1:0] TYPE_LOAD_R24   = 32'd5;
	localparam logic [WORD_W-1:0] TYPE_LOAD_R25   = 32'd6;
	localparam logic [WORD_W-1:0] TYPE_LOAD_R23   = 32'd7;
	localparam logic [WORD_W-1:0] TYPE_LOAD_R4    = 32'd8;
	localparam logic [WORD_W-1:0] TYPE_LOAD_R5    = 32'd9;
	localparam logic [WORD_W-1:0] TYPE_LOAD_R28   = 32'd10;
	localparam logic [WORD_W-1:0] TYPE_LOAD_R29   = 32'd11;
	localparam logic [WORD_W-1:0] TYPE_LOAD_R19   = 32'd12;
	localparam logic [WORD_W-1:0] TYPE_STRIDE     = 32'd13;

	typedef enum logic [KIND_W-1:0] {
		EV_COPY     = 3'd0,
		EV_ZERO     = 3'd1,
		EV_REG_LOAD = 3'd2,
		EV_CALL     = 3'd3,
		EV_STRIDE   = 3'd4,
		EV_TERMINAL = 3'd5,
		EV_UNKNOWN  = 3'd6
	} event_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_UNKNOWN    = 3'd1,
		ST_OVERFLOW   = 3'd2,
		ST_NO_TERM    = 3'd3,
		ST_MISPLACED  = 3'd4
	} status_t;

	function automatic logic [REG_W-1:0] load_reg(input logic [WORD_W-1:0] t);
		logic [REG_W-1:0] r;
		case (t)
			TYPE_LOAD_R24: r = 5'd24;
			TYPE_LOAD_R25: r = 5'd25;
			TYPE_LOAD_R23: r = 5'd23;
			TYPE_LOAD_R4:  r = 5'd4;
			TYPE_LOAD_R5:  r = 5'd5;
			TYPE_LOAD_R28: r = 5'd28;
			TYPE_LOAD_R29: r = 5'd29;
			TYPE_LOAD_R19: r = 5'd19;
			default:       r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> src/launch_record_table_checker_core.sv
// A record taken into the input register moves into the result register once that register is
// free. Throughput: one record per cycle while the output is not stalled; all checks sit in the
// single stage between the two registers. A stalled output holds the result register while the
// input register still takes one more beat.
// Reset (arst_n low, asynchronous) empties both stages, starts a new table at record 0 with no
// error or terminal recorded, and loads the configuration registers with their reset values.
module launch_record_table_checker_core (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [lrtc_pkg::ADDR_W-1:0]         cfg_addr,
	input  logic [lrtc_pkg::WORD_W-1:0]         cfg_wdata,

	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// word_a, word_b, word_c
	input  logic [lrtc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// record type word
	input  logic [lrtc_pkg::WORD_W-1:0]         s_axis_tuser,

	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// record_index, record offset, target_register, transfer bytes, block_count,
	// source_mapped, source_offset, table_status, zero pad
	output logic [lrtc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// event_kind
	output logic [lrtc_pkg::KIND_W-1:0]         m_axis_tuser,
	output logic                                m_axis_tlast
);

	// configuration
	logic [lrtc_pkg::WORD_W-1:0] runtime_base_q;
	logic [lrtc_pkg::OFF_W-1:0]  table_offset_q;
	logic [lrtc_pkg::CNT_W-1:0]  record_count_q;

	// table state
	logic [lrtc_pkg::IDX_W-1:0]    index_q;
	logic [lrtc_pkg::STATUS_W-1:0] first_error_q;
	logic                          term_seen_q;
	logic                          term_misplaced_q;

	// input stage
	logic                        valid_s1;
	logic [lrtc_pkg::WORD_W-1:0] type_s1;
	logic [lrtc_pkg::WORD_W-1:0] a_s1;
	logic [lrtc_pkg::WORD_W-1:0] b_s1;
	logic [lrtc_pkg::WORD_W-1:0] c_s1;

	// result stage
	logic                            valid_s2;
	logic [lrtc_pkg::IDX_W-1:0]      idx_s2;
	logic [lrtc_pkg::OFF_W-1:0]      boff_s2;
	logic [lrtc_pkg::KIND_W-1:0]     kind_s2;
	logic [lrtc_pkg::REG_W-1:0]      treg_s2;
	logic [lrtc_pkg::BYTES_W-1:0]    bytes_s2;
	logic [lrtc_pkg::BLOCKS_W-1:0]   blocks_s2;
	logic                            mapped_s2;
	logic [lrtc_pkg::OFF_W-1:0]      soff_s2;
	logic [lrtc_pkg::STATUS_W-1:0]   status_s2;
	logic                            last_s2;

	logic advance;
	logic take;
	logic fire;

	// combinational results
	logic [lrtc_pkg::CNT_W-1:0]    n_eff;
	logic                          is_last;
	logic [lrtc_pkg::OFF_W-1:0]    boff;
	lrtc_pkg::event_kind_t         kind;
	logic [lrtc_pkg::REG_W-1:0]    treg;
	logic [lrtc_pkg::BYTES_W-1:0]  bytes;
	logic [lrtc_pkg::BLOCKS_W-1:0] blocks;
	logic                          mapped;
	logic [lrtc_pkg::OFF_W-1:0]    soff;
	lrtc_pkg::status_t             err;
	logic [lrtc_pkg::STATUS_W-1:0] fe_next;
	logic [lrtc_pkg::STATUS_W-1:0] status;
	logic                          seen_next;
	logic                          misplaced_next;
	logic                          is_copy;
	logic                          is_term;
	logic [lrtc_pkg::WORD_W-1:0]   cz_count;
	logic [lrtc_pkg::WORD_W-1:0]   cz_base;
	logic [34:0]                   cz_end;
	logic                          cz_ovf;
	logic [34:0]                   st_end;
	logic                          st_ovf;
	logic [32:0]                   src_diff;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign fire          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runtime_base_q <= lrtc_pkg::RESET_RUNTIME_BASE;
			table_offset_q <= lrtc_pkg::RESET_TABLE_OFFSET;
			record_count_q <= lrtc_pkg::RESET_RECORD_COUNT;
		end else if (cfg_we) begin
			case (cfg_addr)
				lrtc_pkg::CFG_RUNTIME_BASE: runtime_base_q <= cfg_wdata;
				lrtc_pkg::CFG_TABLE_OFFSET: table_offset_q <= cfg_wdata[lrtc_pkg::OFF_W-1:0];
				lrtc_pkg::CFG_RECORD_COUNT: record_count_q <= cfg_wdata[lrtc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// shared end-address check for copy (dest + 4*count) and zero (dest + 4*count)
	assign is_copy  = (type_s1 == lrtc_pkg::TYPE_COPY);
	assign is_term  = (type_s1 == lrtc_pkg::TYPE_TERMINAL);
	assign cz_count = is_copy ? c_s1 : b_s1;
	assign cz_base  = is_copy ? b_s1 : a_s1;
	assign cz_end   = {3'b000, cz_base} + {1'b0, cz_count, 2'b00};
	assign cz_ovf   = (cz_count[31:30] != 2'b00) || (cz_end[34:32] != 3'b000);

	// a + 3b + 16*N, with 16*N being b with its low nibble cleared; the -16 is folded into STRIDE_MAX
	assign st_end = {3'b000, a_s1} + {3'b000, b_s1} + {2'b00, b_s1, 1'b0}
		+ {3'b000, b_s1[31:4], 4'b0000};
	assign st_ovf = (b_s1[31:4] != 28'd0) && (st_end > lrtc_pkg::STRIDE_MAX);

	assign src_diff = {1'b0, a_s1} - {1'b0, runtime_base_q};

	always_comb begin
		if (record_count_q == '0) begin
			n_eff = lrtc_pkg::CNT_W'(1);
		end else if (record_count_q > lrtc_pkg::CNT_W'(lrtc_pkg::CNT_LIMIT)) begin
			n_eff = lrtc_pkg::CNT_W'(lrtc_pkg::CNT_LIMIT);
		end else begin
			n_eff = record_count_q;
		end
		is_last = ({1'b0, index_q} + 9'd1) >= n_eff;
		boff    = table_offset_q + {{(lrtc_pkg::OFF_W-lrtc_pkg::IDX_W-4){1'b0}}, index_q, 4'b0000};
	end

	always_comb begin
		kind   = lrtc_pkg::EV_UNKNOWN;
		treg   = '0;
		bytes  = '0;
		blocks = '0;
		mapped = 1'b0;
		soff   = '0;
		err    = lrtc_pkg::ST_OK;
		case (type_s1)
			lrtc_pkg::TYPE_COPY: begin
				kind  = lrtc_pkg::EV_COPY;
				bytes = {cz_count, 2'b00};
				if (cz_ovf) err = lrtc_pkg::ST_OVERFLOW;
				// window test without wrap: no borrow and below the bank size
				if (!src_diff[32] && (src_diff < lrtc_pkg::BANK_SPAN)) begin
					mapped = 1'b1;
					soff   = src_diff[lrtc_pkg::OFF_W-1:0];
				end
			end
			lrtc_pkg::TYPE_ZERO: begin
				kind  = lrtc_pkg::EV_ZERO;
				bytes = {cz_count, 2'b00};
				if (cz_ovf) err = lrtc_pkg::ST_OVERFLOW;
			end
			lrtc_pkg::TYPE_TERMINAL: kind = lrtc_pkg::EV_TERMINAL;
			lrtc_pkg::TYPE_CALL:     kind = lrtc_pkg::EV_CALL;
			lrtc_pkg::TYPE_STRIDE: begin
				kind   = lrtc_pkg::EV_STRIDE;
				blocks = b_s1[31:4];
				if (st_ovf) err = lrtc_pkg::ST_OVERFLOW;
			end
			default: begin
				if (type_s1 >= lrtc_pkg::TYPE_LOAD_R24 && type_s1 <= lrtc_pkg::TYPE_LOAD_R19) begin
					kind = lrtc_pkg::EV_REG_LOAD;
					treg = lrtc_pkg::load_reg(type_s1);
				end else begin
					err = lrtc_pkg::ST_UNKNOWN;
				end
			end
		endcase
	end

	always_comb begin
		seen_next      = term_seen_q || is_term;
		misplaced_next = term_misplaced_q || (is_term && (term_seen_q || !is_last));
		fe_next        = (first_error_q == lrtc_pkg::ST_OK) ? err : first_error_q;
		status         = fe_next;
		if (is_last && status == lrtc_pkg::ST_OK) begin
			if (!seen_next) begin
				status = lrtc_pkg::ST_NO_TERM;
			end else if (misplaced_next) begin
				status = lrtc_pkg::ST_MISPLACED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			index_q          <= '0;
			first_error_q    <= lrtc_pkg::ST_OK;
			term_seen_q      <= 1'b0;
			term_misplaced_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				// start a fresh table after the last record
				if (is_last) begin
					index_q          <= '0;
					first_error_q    <= lrtc_pkg::ST_OK;
					term_seen_q      <= 1'b0;
					term_misplaced_q <= 1'b0;
				end else begin
					index_q          <= index_q + 8'd1;
					first_error_q    <= fe_next;
					term_seen_q      <= seen_next;
					term_misplaced_q <= misplaced_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			type_s1 <= s_axis_tuser;
			a_s1    <= s_axis_tdata[31:0];
			b_s1    <= s_axis_tdata[63:32];
			c_s1    <= s_axis_tdata[95:64];
		end
		if (fire) begin
			idx_s2    <= index_q;
			boff_s2   <= boff;
			kind_s2   <= kind;
			treg_s2   <= treg;
			bytes_s2  <= bytes;
			blocks_s2 <= blocks;
			mapped_s2 <= mapped;
			soff_s2   <= soff;
			status_s2 <= status;
			last_s2   <= is_last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{lrtc_pkg::OUT_PAD_W{1'b0}}, status_s2, soff_s2, mapped_s2,
		blocks_s2, bytes_s2, treg_s2, boff_s2, idx_s2};
	assign m_axis_tuser  = kind_s2;
	assign m_axis_tlast  = last_s2;

`ifndef NO_ASSERTIONS
	// the beat after a table's last record starts again at record 0
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_last |=> index_q == '0 && first_error_q == lrtc_pkg::ST_OK)
		else $error("table state not cleared after last record");

	// terminal verdicts appear only on the last record
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[116:114] == lrtc_pkg::ST_NO_TERM
			|| m_axis_tdata[116:114] == lrtc_pkg::ST_MISPLACED) |-> m_axis_tlast)
		else $error("terminal verdict on a record that is not last");

	// input stalls only when both stages are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && !m_axis_tready)
		else $error("input stalled with room in the pipeline");

	// a recorded error stays until the table ends
	assert property (@(posedge clk) disable iff (!arst_n)
		first_error_q != lrtc_pkg::ST_OK && !(fire && is_last) |=> first_error_q == $past(first_error_q))
		else $error("first error changed within a table");
`endif

endmodule
